// ===== rtl/core/source_text_tokenizer_unit_macros.svh =====
// Assertion macros shared by the checker.
// Each macro expands to one labeled concurrent assertion on the clock clk,
// disabled while rst_n is low.
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/stt_pkg.sv =====
package stt_pkg;

    localparam int MAX_RES = 3;

    // Token kinds.
    localparam logic [5:0] K_EOF      = 6'd0;
    localparam logic [5:0] K_DOT      = 6'd8;
    localparam logic [5:0] K_SLASH    = 6'd27;
    localparam logic [5:0] K_STRING   = 6'd28;
    localparam logic [5:0] K_IDENT    = 6'd29;
    localparam logic [5:0] K_INTEGER  = 6'd30;
    localparam logic [5:0] K_DECIMAL  = 6'd31;
    localparam logic [5:0] K_BOOLEAN  = 6'd32;
    localparam logic [5:0] K_KEYWORD0 = 6'd33;
    localparam logic [5:0] K_ERROR    = 6'd41;

    // Error codes.
    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_CHAR     = 2'd1;
    localparam logic [1:0] E_STRING   = 2'd2;
    localparam logic [1:0] E_OVERFLOW = 2'd3;

    // Register byte addresses.
    localparam logic [2:0] ADDR_FIRST_LINE = 3'd0;

    localparam logic [30:0] INT_TOP = 31'h7FFF_FFFF;

    // Reserved words, first character in the low byte, and their lengths.
    localparam logic [7:0][55:0] KW_TEXT = '{
        56'h00_00_65_6C_69_68_77,      // while
        56'h00_6E_72_75_74_65_72,      // return
        56'h00_00_74_6E_69_72_70,      // print
        56'h00_00_00_00_74_65_6C,      // let
        56'h00_00_00_00_00_66_69,      // if
        56'h00_00_00_00_72_6F_66,      // for
        56'h00_00_00_65_73_6C_65,      // else
        56'h00_00_6B_61_65_72_62       // break
    };
    localparam logic [7:0][2:0] KW_LEN = '{
        3'd5, 3'd6, 3'd5, 3'd3, 3'd2, 3'd3, 3'd4, 3'd5
    };
    localparam logic [55:0] TXT_TRUE  = 56'h00_00_00_65_75_72_74;
    localparam logic [55:0] TXT_FALSE = 56'h00_00_65_73_6C_61_66;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_marker;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [31:0] start_offset;
        logic [15:0] text_length;
        logic [15:0] line_number;
        logic [30:0] int_value;
        logic        bool_value;
        logic [1:0]  error_code;
        logic        run_last;
    } out_item_t;

    // Results of one input item, passed from the scanner to the result queue.
    typedef struct packed {
        out_item_t [MAX_RES-1:0] items;
        logic [1:0]              count;
    } res_bundle_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0C || c == 8'h0B;
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            8'h28:   return 6'd1;
            8'h29:   return 6'd2;
            8'h5B:   return 6'd3;
            8'h5D:   return 6'd4;
            8'h7B:   return 6'd5;
            8'h7D:   return 6'd6;
            8'h2C:   return 6'd7;
            8'h2E:   return 6'd8;
            8'h2A:   return 6'd9;
            8'h3B:   return 6'd10;
            default: return 6'd0;
        endcase
    endfunction

    // Kind of the one-byte form of a pair operator; the two-byte form is one more.
    function automatic logic [5:0] pair_kind(input logic [7:0] c);
        case (c)
            8'h2B:   return 6'd11;
            8'h2D:   return 6'd13;
            8'h21:   return 6'd15;
            8'h3D:   return 6'd17;
            8'h3E:   return 6'd19;
            8'h3C:   return 6'd21;
            8'h26:   return 6'd23;
            8'h7C:   return 6'd25;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [7:0] pair_second(input logic [7:0] c);
        case (c)
            8'h2B:   return 8'h2B;
            8'h2D:   return 8'h2D;
            8'h26:   return 8'h26;
            8'h7C:   return 8'h7C;
            default: return 8'h3D;
        endcase
    endfunction

    // True when the first len bytes of the buffer equal the word and len is its length.
    function automatic logic word_equal(input logic [55:0] buf_text, input logic [15:0] len,
                                        input logic [55:0] word, input logic [2:0] wlen);
        logic ok;
        ok = (len == 16'(wlen));
        for (int i = 0; i < 7; i++) begin
            if (i < int'(wlen) && buf_text[i*8 +: 8] != word[i*8 +: 8]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic [6:0] word_kind(input logic [55:0] buf_text,
                                             input logic [15:0] len);
        logic [6:0] r;
        r = {K_IDENT, 1'b0};
        if (word_equal(buf_text, len, TXT_TRUE, 3'd4)) begin
            r = {K_BOOLEAN, 1'b1};
        end else if (word_equal(buf_text, len, TXT_FALSE, 3'd5)) begin
            r = {K_BOOLEAN, 1'b0};
        end else begin
            for (int i = 7; i >= 0; i--) begin
                if (word_equal(buf_text, len, KW_TEXT[i], KW_LEN[i])) begin
                    r = {K_KEYWORD0 + 6'(i), 1'b0};
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/source_text_tokenizer_unit.sv =====
// Latency: the first result of an item is shown in the cycle after it is accepted.
// Throughput: one item per cycle while each item yields at most one result and out_ready
// is high; an item with two or three results holds the input while the result queue
// drains, one result per cycle while out_ready is high.
// Reset (rst_n low, asynchronous) clears the scanner to idle at offset 0, line 1,
// empties the result queue and sets first_line to 1.
module source_text_tokenizer_unit #(
    parameter int OFFSET_BITS = 32,
    parameter int LENGTH_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  stt_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output stt_pkg::out_item_t out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // The configuration port has one register, first_line. A write to it also
    // loads the scanner's line counter unless an item is accepted in that cycle.
    logic [15:0] first_line_reg;
    logic        cfg_write;
    logic        in_fire;

    stt_pkg::res_bundle_t bundle;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == stt_pkg::ADDR_FIRST_LINE);
    assign prdata    = (paddr == stt_pkg::ADDR_FIRST_LINE) ? {16'd0, first_line_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            first_line_reg <= 16'd1;
        end else if (cfg_write) begin
            first_line_reg <= pwdata[15:0];
        end
    end

    // An item is taken when the result queue can hold everything it produces.
    assign in_fire = in_valid && in_ready;

    // The scanner holds the token state and works out, in the same cycle as the
    // item arrives, every result the item causes (at most three).
    stt_scan #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_fire),
        .item       (in_item),
        .line_load  (cfg_write),
        .first_line (cfg_write ? pwdata[15:0] : first_line_reg),
        .bundle     (bundle)
    );

    // The result queue is the output register: it is loaded with all results of
    // an item at once and hands them out in order.
    stt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .bundle    (bundle),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ===== rtl/core/stt_scan.sv =====
module stt_scan #(
    parameter int OFFSET_BITS = 32,
    parameter int LENGTH_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  stt_pkg::in_item_t     item,
    input  logic                  line_load,
    input  logic [15:0]           first_line,
    output stt_pkg::res_bundle_t  bundle
);

    localparam int LEN_LIM = (LENGTH_BITS >= 16) ? 65535 : (1 << LENGTH_BITS) - 1;

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_NUM, M_NUMDOT, M_DEC, M_STR, M_REM, M_SLASH, M_PAIR
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] beg_reg, beg_next;
    logic [15:0]            line_reg, line_next;
    logic [7:0]             pend_reg, pend_next;
    logic [6:0][7:0]        wbuf_reg, wbuf_next;
    logic [15:0]            wlen_reg, wlen_next;
    logic [30:0]            acc_reg, acc_next;
    logic                   ovf_reg, ovf_next;

    logic [OFFSET_BITS-1:0] pos_inc, dot_pos;
    logic [7:0]             c;
    logic [34:0]            acc_times;
    logic [6:0]             wkind;
    logic [5:0]             pkind;
    logic                   fall;
    logic [1:0]             cnt;
    stt_pkg::out_item_t [stt_pkg::MAX_RES-1:0] res;

    function automatic stt_pkg::out_item_t mk(input logic [5:0] kind,
                                              input logic [OFFSET_BITS-1:0] b,
                                              input logic [OFFSET_BITS-1:0] e,
                                              input logic [30:0] ival,
                                              input logic bval,
                                              input logic [1:0] err,
                                              input logic [15:0] line);
        stt_pkg::out_item_t o;
        logic [OFFSET_BITS-1:0] diff;
        diff = e - b;
        o.token_kind   = kind;
        o.start_offset = 32'(b);
        o.text_length  = (diff > OFFSET_BITS'(LEN_LIM)) ? 16'(LEN_LIM) : 16'(diff);
        o.line_number  = line;
        o.int_value    = ival;
        o.bool_value   = bval;
        o.error_code   = err;
        o.run_last     = 1'b0;
        return o;
    endfunction

    assign c         = item.text_byte;
    assign pos_inc   = pos_reg + OFFSET_BITS'(1);
    assign dot_pos   = pos_reg - OFFSET_BITS'(1);
    assign acc_times = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + 35'(c[3:0]);
    assign wkind     = stt_pkg::word_kind(wbuf_reg, wlen_reg);
    assign pkind     = stt_pkg::pair_kind(pend_reg);

    always_comb
    begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        beg_next  = beg_reg;
        line_next = line_reg;
        pend_next = pend_reg;
        wbuf_next = wbuf_reg;
        wlen_next = wlen_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        res       = '0;
        cnt       = 2'd0;
        fall      = 1'b1;

        if (item.end_marker) begin
            case (mode_reg)
                M_WORD:
                begin
                    res[cnt] = mk(wkind[6:1], beg_reg, pos_reg, '0, wkind[0],
                                  stt_pkg::E_NONE, line_reg);
                    cnt = cnt + 2'd1;
                end
                M_NUM:
                begin
                    res[cnt] = mk(stt_pkg::K_INTEGER, beg_reg, pos_reg, acc_reg, 1'b0,
                                  ovf_reg ? stt_pkg::E_OVERFLOW : stt_pkg::E_NONE, line_reg);
                    cnt = cnt + 2'd1;
                end
                M_NUMDOT:
                begin
                    res[cnt] = mk(stt_pkg::K_INTEGER, beg_reg, dot_pos, acc_reg, 1'b0,
                                  ovf_reg ? stt_pkg::E_OVERFLOW : stt_pkg::E_NONE, line_reg);
                    cnt = cnt + 2'd1;
                    res[cnt] = mk(stt_pkg::K_DOT, dot_pos, pos_reg, '0, 1'b0,
                                  stt_pkg::E_NONE, line_reg);
                    cnt = cnt + 2'd1;
                end
                M_DEC:
                begin
                    res[cnt] = mk(stt_pkg::K_DECIMAL, beg_reg, pos_reg, '0, 1'b0,
                                  stt_pkg::E_NONE, line_reg);
                    cnt = cnt + 2'd1;
                end
                M_STR:
                begin
                    res[cnt] = mk(stt_pkg::K_ERROR, beg_reg, pos_reg, '0, 1'b0,
                                  stt_pkg::E_STRING, line_reg);
                    cnt = cnt + 2'd1;
                end
                M_SLASH:
                begin
                    res[cnt] = mk(stt_pkg::K_SLASH, beg_reg, pos_reg, '0, 1'b0,
                                  stt_pkg::E_NONE, line_reg);
                    cnt = cnt + 2'd1;
                end
                M_PAIR:
                begin
                    res[cnt] = mk(pkind, beg_reg, pos_reg, '0, 1'b0, stt_pkg::E_NONE, line_reg);
                    cnt = cnt + 2'd1;
                end
                default:
                begin
                end
            endcase
            res[cnt] = mk(stt_pkg::K_EOF, pos_reg, pos_reg, '0, 1'b0, stt_pkg::E_NONE, line_reg);
            cnt = cnt + 2'd1;
            // The stream restarts after the end marker.
            mode_next = M_IDLE;
            pos_next  = '0;
            beg_next  = '0;
            line_next = first_line;
            pend_next = '0;
            wlen_next = '0;
            acc_next  = '0;
            ovf_next  = 1'b0;
        end else begin
            case (mode_reg)
                M_WORD:
                begin
                    if (stt_pkg::is_letter(c) || stt_pkg::is_digit(c)) begin
                        if (wlen_reg < 16'd7) begin
                            wbuf_next[wlen_reg[2:0]] = c;
                        end
                        if (wlen_reg != 16'hFFFF) begin
                            wlen_next = wlen_reg + 16'd1;
                        end
                        pos_next = pos_inc;
                        fall     = 1'b0;
                    end else begin
                        res[cnt] = mk(wkind[6:1], beg_reg, pos_reg, '0, wkind[0],
                                      stt_pkg::E_NONE, line_reg);
                        cnt = cnt + 2'd1;
                    end
                end
                M_NUM:
                begin
                    if (stt_pkg::is_digit(c)) begin
                        if (acc_times > 35'(stt_pkg::INT_TOP)) begin
                            acc_next = stt_pkg::INT_TOP;
                            ovf_next = 1'b1;
                        end else begin
                            acc_next = acc_times[30:0];
                        end
                        pos_next = pos_inc;
                        fall     = 1'b0;
                    end else if (c == 8'h2E) begin
                        mode_next = M_NUMDOT;
                        pos_next  = pos_inc;
                        fall      = 1'b0;
                    end else begin
                        res[cnt] = mk(stt_pkg::K_INTEGER, beg_reg, pos_reg, acc_reg, 1'b0,
                                      ovf_reg ? stt_pkg::E_OVERFLOW : stt_pkg::E_NONE,
                                      line_reg);
                        cnt = cnt + 2'd1;
                    end
                end
                M_NUMDOT:
                begin
                    if (stt_pkg::is_digit(c)) begin
                        mode_next = M_DEC;
                        pos_next  = pos_inc;
                        fall      = 1'b0;
                    end else begin
                        res[cnt] = mk(stt_pkg::K_INTEGER, beg_reg, dot_pos, acc_reg, 1'b0,
                                      ovf_reg ? stt_pkg::E_OVERFLOW : stt_pkg::E_NONE,
                                      line_reg);
                        cnt = cnt + 2'd1;
                        res[cnt] = mk(stt_pkg::K_DOT, dot_pos, pos_reg, '0, 1'b0,
                                      stt_pkg::E_NONE, line_reg);
                        cnt = cnt + 2'd1;
                    end
                end
                M_DEC:
                begin
                    if (stt_pkg::is_digit(c)) begin
                        pos_next = pos_inc;
                        fall     = 1'b0;
                    end else begin
                        res[cnt] = mk(stt_pkg::K_DECIMAL, beg_reg, pos_reg, '0, 1'b0,
                                      stt_pkg::E_NONE, line_reg);
                        cnt = cnt + 2'd1;
                    end
                end
                M_STR:
                begin
                    fall     = 1'b0;
                    pos_next = pos_inc;
                    if (c == 8'h0A) begin
                        line_next = line_reg + 16'd1;
                    end
                    if (c == 8'h22) begin
                        res[cnt] = mk(stt_pkg::K_STRING, beg_reg, pos_inc, '0, 1'b0,
                                      stt_pkg::E_NONE, line_reg);
                        cnt = cnt + 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_REM:
                begin
                    fall     = 1'b0;
                    pos_next = pos_inc;
                    if (c == 8'h0A) begin
                        line_next = line_reg + 16'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_SLASH:
                begin
                    if (c == 8'h2F) begin
                        pos_next  = pos_inc;
                        mode_next = M_REM;
                        fall      = 1'b0;
                    end else begin
                        res[cnt] = mk(stt_pkg::K_SLASH, beg_reg, pos_reg, '0, 1'b0,
                                      stt_pkg::E_NONE, line_reg);
                        cnt = cnt + 2'd1;
                    end
                end
                M_PAIR:
                begin
                    if (pkind != 6'd0 && c == stt_pkg::pair_second(pend_reg)) begin
                        res[cnt] = mk(pkind + 6'd1, beg_reg, pos_inc, '0, 1'b0,
                                      stt_pkg::E_NONE, line_reg);
                        cnt = cnt + 2'd1;
                        pos_next  = pos_inc;
                        mode_next = M_IDLE;
                        fall      = 1'b0;
                    end else begin
                        res[cnt] = mk(pkind, beg_reg, pos_reg, '0, 1'b0,
                                      stt_pkg::E_NONE, line_reg);
                        cnt = cnt + 2'd1;
                    end
                end
                default:
                begin
                end
            endcase

            // Start of a new token, or a skipped blank or newline, from the idle state or after closing one.
            if (fall) begin
                mode_next = M_IDLE;
                beg_next  = pos_reg;
                pos_next  = pos_inc;
                if (c == 8'h0A) begin
                    line_next = line_reg + 16'd1;
                end else if (stt_pkg::is_blank(c)) begin
                    mode_next = M_IDLE;
                end else if (stt_pkg::single_kind(c) != 6'd0) begin
                    res[cnt] = mk(stt_pkg::single_kind(c), pos_reg, pos_inc, '0, 1'b0,
                                  stt_pkg::E_NONE, line_reg);
                    cnt = cnt + 2'd1;
                end else if (stt_pkg::pair_kind(c) != 6'd0) begin
                    pend_next = c;
                    mode_next = M_PAIR;
                end else if (c == 8'h2F) begin
                    mode_next = M_SLASH;
                end else if (c == 8'h22) begin
                    mode_next = M_STR;
                end else if (stt_pkg::is_letter(c)) begin
                    wbuf_next[0] = c;
                    wlen_next    = 16'd1;
                    mode_next    = M_WORD;
                end else if (stt_pkg::is_digit(c)) begin
                    acc_next  = 31'(c[3:0]);
                    ovf_next  = 1'b0;
                    mode_next = M_NUM;
                end else begin
                    res[cnt] = mk(stt_pkg::K_ERROR, pos_reg, pos_inc, '0, 1'b0,
                                  stt_pkg::E_CHAR, line_reg);
                    cnt = cnt + 2'd1;
                end
            end
        end

        for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
            res[i].run_last = (2'(i + 1) == cnt);
        end
        bundle.items = res;
        bundle.count = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
            pos_reg  <= '0;
            beg_reg  <= '0;
            line_reg <= 16'd1;
            pend_reg <= '0;
            wlen_reg <= '0;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else if (fire) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            beg_reg  <= beg_next;
            line_reg <= line_next;
            pend_reg <= pend_next;
            wlen_reg <= wlen_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
        end else if (line_load) begin
            line_reg <= first_line;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) begin
            wbuf_reg <= wbuf_next;
        end
    end

endmodule

// ===== rtl/core/stt_outq.sv =====
module stt_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  stt_pkg::res_bundle_t bundle,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output stt_pkg::out_item_t   out_item
);

    stt_pkg::out_item_t [stt_pkg::MAX_RES-1:0] q_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = q_reg[0];
    // A new item may enter once the queue is empty or its last entry leaves now.
    assign room      = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= bundle.count;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            q_reg <= bundle.items;
        end else if (pop) begin
            for (int i = 0; i < stt_pkg::MAX_RES - 1; i++) begin
                q_reg[i] <= q_reg[i+1];
            end
        end
    end

endmodule

// ===== rtl/core/stt_checker.sv =====
`include "source_text_tokenizer_unit_macros.svh"

module stt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input stt_pkg::out_item_t out_item,
    input logic               pready
);

    logic stall;
    logic eof_shown;
    logic eof_ok;
    logic err_shown;
    logic err_kind_ok;

    assign stall       = out_valid && !out_ready;
    assign eof_shown   = out_valid && (out_item.token_kind == stt_pkg::K_EOF);
    assign eof_ok      = out_item.run_last && (out_item.text_length == 16'd0);
    assign err_shown   = out_valid && (out_item.error_code != stt_pkg::E_NONE);
    assign err_kind_ok = (out_item.token_kind == stt_pkg::K_ERROR) ||
                         (out_item.token_kind == stt_pkg::K_INTEGER);

    `STT_ASSERT_NEXT(a_hold, stall, out_valid && $stable(out_item), "result changed in stall")
    `STT_ASSERT_NOW(a_pready, 1'b1, pready, "pready dropped")
    `STT_ASSERT_NOW(a_eof_last, eof_shown, eof_ok, "end of file item not last or not empty")
    `STT_ASSERT_NOW(a_err_kind, err_shown, err_kind_ok, "error code on wrong token kind")

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (.*);
